// ===== rtl/todc_pkg.sv =====
// ----------------------------------------------------------------------------
// todc_pkg
// types and calendar helpers for the time-of-day continuity core
// ----------------------------------------------------------------------------
`default_nettype none

package todc_pkg;

   localparam logic [6:0]  SECONDS_PER_MINUTE = 7'd60;
   localparam logic [6:0]  MINUTES_PER_HOUR   = 7'd60;
   localparam logic [5:0]  HOURS_PER_DAY      = 6'd24;
   localparam logic [3:0]  MONTH_FEB          = 4'd2;
   localparam logic [3:0]  MONTH_APR          = 4'd4;
   localparam logic [3:0]  MONTH_JUN          = 4'd6;
   localparam logic [3:0]  MONTH_SEP          = 4'd9;
   localparam logic [3:0]  MONTH_NOV          = 4'd11;
   localparam logic [3:0]  MONTH_DEC          = 4'd12;
   localparam logic [3:0]  MONTH_JAN          = 4'd1;
   localparam logic [4:0]  FIRST_DAY          = 5'd1;

   // inverse of 25 modulo 4096; y is a multiple of 25 iff y*inv mod 4096 <= 4095/25
   localparam logic [11:0] INV_25_MOD_4096    = 12'd3113;
   localparam logic [11:0] MULT_25_LIMIT      = 12'd163;

   typedef struct packed {
      logic [11:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
      logic [4:0]  in_hour;
      logic [5:0]  in_minute;
      logic [5:0]  in_second;
      logic [31:0] in_total_seconds;
      logic        in_valid;
   } todc_req_type;

   typedef struct packed {
      logic        status_valid;
      logic        aligned_updated;
      logic [11:0] next_year;
      logic [3:0]  next_month;
      logic [4:0]  next_day;
      logic [4:0]  next_hour;
      logic [5:0]  next_minute;
      logic [5:0]  next_second;
      logic [31:0] next_total_seconds;
   } todc_rsp_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [31:0] total;
   } todc_time_type;

   // gregorian rule: div by 4, and not by 100 unless by 400
   function automatic logic is_leap_year(input logic [11:0] year);
      logic [11:0] scaled;
      logic        div4;
      logic        div16;
      logic        div25;
      scaled = 12'(year * INV_25_MOD_4096);
      div4   = (year[1:0] == 2'd0);
      div16  = (year[3:0] == 4'd0);
      div25  = (scaled <= MULT_25_LIMIT);
      return div4 && (!div25 || div16);
   endfunction

   // month length; months outside 1..12 count as 31 days
   function automatic logic [4:0] month_days(input logic [11:0] year,
                                             input logic [3:0]  month);
      logic [4:0] len;
      unique case (month)
         MONTH_FEB: len = is_leap_year(year) ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // advance by one second with carries up to the year
   function automatic todc_time_type advance_second(input todc_time_type t);
      todc_time_type r;
      logic [6:0]    sec_inc;
      logic [6:0]    min_inc;
      logic [5:0]    hour_inc;
      r        = t;
      r.total  = t.total + 32'd1;
      sec_inc  = {1'b0, t.second} + 7'd1;
      min_inc  = {1'b0, t.minute} + 7'd1;
      hour_inc = {1'b0, t.hour} + 6'd1;
      if (sec_inc < SECONDS_PER_MINUTE) begin
         r.second = sec_inc[5:0];
      end else begin
         r.second = 6'd0;
         if (min_inc < MINUTES_PER_HOUR) begin
            r.minute = min_inc[5:0];
         end else begin
            r.minute = 6'd0;
            if (hour_inc < HOURS_PER_DAY) begin
               r.hour = hour_inc[4:0];
            end else begin
               r.hour = 5'd0;
               if (t.day < month_days(t.year, t.month)) begin
                  r.day = t.day + 5'd1;
               end else begin
                  r.day = FIRST_DAY;
                  if (t.month < MONTH_DEC) begin
                     r.month = t.month + 4'd1;
                  end else begin
                     r.month = MONTH_JAN;
                     r.year  = t.year + 12'd1;
                  end
               end
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tod_continuity_and_next_second_core.sv =====
// ----------------------------------------------------------------------------
// tod_continuity_and_next_second_core
// checks the running seconds count of each time-of-day report against the
// previous one and, once a baseline exists, returns the report advanced by one second
// ----------------------------------------------------------------------------
//
//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+--------------------------
//  request | req_valid, req_stall, req_data | in        | one decoded report item
//  result  | rsp_valid, rsp_stall, rsp_data | out       | status and advanced time
//
//  one item per cycle sustained while rsp_stall stays low; an accepted item's
//  result is registered into the result register, or into the skid register
//  if the previous result still waits; this two-entry output lets an item be
//  accepted while the previous result still waits; req_stall rises only
//  when both entries are full or during reset, and is skid_valid_ff ORed with
//  reset; synchronous active-high reset clears the baseline, the held aligned
//  time and both output entries; req_stall is held high during reset
//
`default_nettype none

module tod_continuity_and_next_second_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire todc_pkg::todc_req_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output todc_pkg::todc_rsp_type     rsp_data
);

   import todc_pkg::*;

   // handshake
   logic          accept;
   logic          out_take;

   // baseline state
   logic          baseline_seen_ff;
   logic          baseline_seen_in;
   logic [31:0]   baseline_total_ff;
   logic [31:0]   baseline_total_in;
   todc_time_type held_ff;
   todc_time_type held_in;

   // output entries
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   todc_rsp_type  rsp_ff;
   todc_rsp_type  rsp_in;
   logic          skid_valid_ff;
   logic          skid_valid_in;
   todc_rsp_type  skid_ff;
   todc_rsp_type  skid_in;

   // datapath
   todc_time_type cur_time;
   todc_time_type advanced;
   todc_time_type held_time;
   logic          continuity_ok;
   todc_rsp_type  result;

   assign req_stall = skid_valid_ff || reset;
   assign accept    = req_valid && !req_stall;
   assign out_take  = rsp_valid_ff && !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // report advance and continuity check
   always_comb begin
      cur_time.year   = req_data.in_year;
      cur_time.month  = req_data.in_month;
      cur_time.day    = req_data.in_day;
      cur_time.hour   = req_data.in_hour;
      cur_time.minute = req_data.in_minute;
      cur_time.second = req_data.in_second;
      cur_time.total  = req_data.in_total_seconds;

      advanced      = advance_second(cur_time);
      continuity_ok = (req_data.in_total_seconds == baseline_total_ff + 32'd1);

      // the first report after reset only sets the baseline
      held_time = baseline_seen_ff ? advanced : held_ff;

      result.status_valid       = req_data.in_valid && (!baseline_seen_ff || continuity_ok);
      result.aligned_updated    = baseline_seen_ff;
      result.next_year          = held_time.year;
      result.next_month         = held_time.month;
      result.next_day           = held_time.day;
      result.next_hour          = held_time.hour;
      result.next_minute        = held_time.minute;
      result.next_second        = held_time.second;
      result.next_total_seconds = held_time.total;
   end

   // next state for baseline and the two output entries
   always_comb begin
      baseline_seen_in  = baseline_seen_ff;
      baseline_total_in = baseline_total_ff;
      held_in           = held_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_in            = rsp_ff;
      skid_valid_in     = skid_valid_ff;
      skid_in           = skid_ff;

      if (accept) begin
         baseline_seen_in  = 1'b1;
         baseline_total_in = req_data.in_total_seconds;
         held_in           = held_time;
         // skid is empty whenever an item is accepted
         if (!rsp_valid_ff || out_take) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_seen_ff  <= 1'b0;
         baseline_total_ff <= 32'd0;
         held_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         baseline_seen_ff  <= baseline_seen_in;
         baseline_total_ff <= baseline_total_in;
         held_ff           <= held_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   // skid entry only fills behind a waiting result
   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid without a result entry");

   // an accepted item always lands in an output entry
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result entry");

   // an updated aligned time needs a baseline
   a_updated_after_baseline : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.aligned_updated) |-> baseline_seen_ff)
      else $error("aligned time updated before any baseline report");

endmodule

`default_nettype wire
